### design/pcpl_pkg.sv
// ---------------------------------------------------------------------------
// Point labeler package
// Types, field widths and codes shared by the region labeler modules.
// ---------------------------------------------------------------------------
package pcpl_pkg;

	localparam int COORD_W   = 16;
	localparam int RANK_W    = 8;
	localparam int TAG_W     = 16;
	localparam int SCORE_W   = 34;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int IDX_W     = 4;
	localparam int ACTIVE_W  = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 5;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OCTANT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] cut;
		logic signed [RANK_W-1:0]  rank;
		logic [TAG_W-1:0]          tag;
	} entry_t;

	typedef struct packed {
		logic                      busy;
		logic                      valid;
		logic                      above_cut;
		logic signed [RANK_W-1:0]  rank;
		logic signed [SCORE_W-1:0] dot;
		logic [TAG_W-1:0]          tag;
	} dot_out_t;

endpackage

### design/priority_cone_point_labeler.sv
// ---------------------------------------------------------------------------
// Priority cone point labeler
// Loads a table of regions and labels points by scanning the active entries
// through one shared dot product unit, keeping the best-ranked hit.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | cmd, entry_index, vec_*, cut_value,
//           |                      | region_rank, region_tag
//  out      | out_valid/out_ready  | point_label, best_score, region_hit
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//
//  A load request writes its table entry and the labeler stays idle. A
//  classify request reads n = min(active_regions, MAX_REGIONS) table entries,
//  drains the dot product unit and loads the output register; with n = 0 it skips the reads.
//  The next request is taken while a result waits in the output register;
//  a finished classify holds until that register is free.
//  Reset clears control state and configuration; the table is not cleared.
// ---------------------------------------------------------------------------
module priority_cone_point_labeler #(
	parameter int MAX_REGIONS   = 16,
	parameter int FRACTION_BITS = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   cmd,
	input  logic [pcpl_pkg::IDX_W-1:0]             entry_index,
	input  logic signed [pcpl_pkg::COORD_W-1:0]    vec_x,
	input  logic signed [pcpl_pkg::COORD_W-1:0]    vec_y,
	input  logic signed [pcpl_pkg::COORD_W-1:0]    vec_z,
	input  logic signed [pcpl_pkg::COORD_W-1:0]    cut_value,
	input  logic signed [pcpl_pkg::RANK_W-1:0]     region_rank,
	input  logic [pcpl_pkg::TAG_W-1:0]             region_tag,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pcpl_pkg::TAG_W-1:0]             point_label,
	output logic signed [pcpl_pkg::SCORE_W-1:0]    best_score,
	output logic                                   region_hit,
	input  logic                                   cfg_we,
	input  logic [pcpl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pcpl_pkg::CFG_W-1:0]             cfg_wdata
);
	import pcpl_pkg::*;

	localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	state_t state_q, state_d;

	logic [ACTIVE_W-1:0]       active_regions_q;
	logic                      octant_default_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          limit_q;
	logic [CNT_W-1:0]          limit_d;
	point_t                    pt_q;
	logic [TAG_W-1:0]          label_q;
	logic signed [RANK_W-1:0]  best_rank_q;
	logic signed [SCORE_W-1:0] best_score_q;
	logic                      hit_q;
	logic                      rd_valid_s1;

	logic                      out_valid_q;
	logic [TAG_W-1:0]          out_label_q;
	logic signed [SCORE_W-1:0] out_score_q;
	logic                      out_hit_q;

	logic                      accept;
	logic                      take_load;
	logic                      take_classify;
	logic                      issue;
	logic                      last_issue;
	logic                      finish_load;
	logic                      win;
	logic [TAG_W-1:0]          label_init;

	entry_t                    wr_entry;
	entry_t                    rd_entry;
	dot_out_t                  dot_res;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_regions_q <= '0;
			octant_default_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE: active_regions_q <= cfg_wdata;
				REG_OCTANT: octant_default_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign accept        = in_valid & in_ready;
	assign take_load     = accept & (cmd == CMD_LOAD) & (32'(entry_index) < MAX_REGIONS);
	assign take_classify = accept & (cmd == CMD_CLASSIFY);
	assign last_issue    = (cnt_q + CNT_W'(1)) == limit_q;
	assign limit_d       = (32'(active_regions_q) > MAX_REGIONS) ?
	                       CNT_W'(MAX_REGIONS) : CNT_W'(active_regions_q);
	assign label_init    = octant_default_q ?
	                       TAG_W'({vec_z[COORD_W-1], vec_y[COORD_W-1], vec_x[COORD_W-1]}) :
	                       '0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take_classify) begin
					state_d = (limit_d == '0) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_valid_s1 && !dot_res.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ready    = 1'b0;
		issue       = 1'b0;
		finish_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready    = 1'b1;
			ST_SCAN:   issue       = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: finish_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			limit_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (take_classify) begin
				cnt_q   <= '0;
				limit_q <= limit_d;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Best candidate tracking
	assign win = dot_res.valid && dot_res.above_cut &&
	             ((dot_res.rank > best_rank_q) ||
	              ((dot_res.rank == best_rank_q) && (dot_res.dot > best_score_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			best_rank_q  <= '0;
			best_score_q <= '0;
		end else if (take_classify) begin
			hit_q        <= 1'b0;
			best_rank_q  <= '0;
			best_score_q <= '0;
		end else if (win) begin
			hit_q        <= 1'b1;
			best_rank_q  <= dot_res.rank;
			best_score_q <= dot_res.dot;
		end
	end

	always_ff @(posedge clk) begin
		if (take_classify) begin
			pt_q.x  <= vec_x;
			pt_q.y  <= vec_y;
			pt_q.z  <= vec_z;
			label_q <= label_init;
		end else if (win) begin
			label_q <= dot_res.tag;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_load) begin
			out_label_q <= label_q;
			out_score_q <= best_score_q;
			out_hit_q   <= hit_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign point_label = out_label_q;
	assign best_score  = out_score_q;
	assign region_hit  = out_hit_q;

	always_comb begin
		wr_entry.x    = vec_x;
		wr_entry.y    = vec_y;
		wr_entry.z    = vec_z;
		wr_entry.cut  = cut_value;
		wr_entry.rank = region_rank;
		wr_entry.tag  = region_tag;
	end

	pcpl_table #(
		.DEPTH (MAX_REGIONS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (take_load),
		.waddr (AW'(entry_index)),
		.wdata (wr_entry),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rd_entry)
	);

	pcpl_dot #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid_s1),
		.pt       (pt_q),
		.ent      (rd_entry),
		.res      (dot_res)
	);

`ifndef ASSERT_OFF
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q < limit_q)
		else $error("scan index past limit");

	a_pipe_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid_s1 || dot_res.busy) |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("dot unit busy outside scan");

	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!hit_q |-> (best_score_q == '0 && best_rank_q == '0))
		else $error("best score set without hit");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result raised outside finish");
`endif

endmodule

### design/pcpl_table.sv
// ---------------------------------------------------------------------------
// Region table
// Single-port-write, single-read memory of region entries; read data is
// registered.
// ---------------------------------------------------------------------------
module pcpl_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  pcpl_pkg::entry_t wdata,
	input  logic [AW-1:0]    raddr,
	output pcpl_pkg::entry_t rdata
);
	import pcpl_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_entry_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_entry_s1 <= mem_q[raddr];
	end

	assign rdata = rd_entry_s1;

endmodule

### design/pcpl_dot.sv
// ---------------------------------------------------------------------------
// Shared dot product unit
// Two-stage unit: three products, then sum and cut compare. Takes one table
// entry per cycle.
// ---------------------------------------------------------------------------
module pcpl_dot #(
	parameter int FRACTION_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pcpl_pkg::point_t   pt,
	input  pcpl_pkg::entry_t   ent,
	output pcpl_pkg::dot_out_t res
);
	import pcpl_pkg::*;

	localparam int CUT_SH_W = COORD_W + FRACTION_BITS;
	localparam int CMP_W    = (CUT_SH_W > SCORE_W) ? CUT_SH_W : SCORE_W;

	logic                      valid_s2;
	logic signed [PROD_W-1:0]  prod_x_s2;
	logic signed [PROD_W-1:0]  prod_y_s2;
	logic signed [PROD_W-1:0]  prod_z_s2;
	logic signed [COORD_W-1:0] cut_s2;
	logic signed [RANK_W-1:0]  rank_s2;
	logic [TAG_W-1:0]          tag_s2;

	logic                      valid_s3;
	logic                      above_s3;
	logic signed [SCORE_W-1:0] dot_s3;
	logic signed [RANK_W-1:0]  rank_s3;
	logic [TAG_W-1:0]          tag_s3;

	logic signed [SCORE_W-1:0]  dot_sum;
	logic signed [CUT_SH_W-1:0] cut_sh;
	logic signed [CMP_W-1:0]    cut_ext;
	logic signed [CMP_W-1:0]    dot_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s2 <= pt.x * ent.x;
		prod_y_s2 <= pt.y * ent.y;
		prod_z_s2 <= pt.z * ent.z;
		cut_s2    <= ent.cut;
		rank_s2   <= ent.rank;
		tag_s2    <= ent.tag;
		dot_s3    <= dot_sum;
		above_s3  <= dot_ext > cut_ext;
		rank_s3   <= rank_s2;
		tag_s3    <= tag_s2;
	end

	always_comb begin
		dot_sum = SCORE_W'(prod_x_s2) + SCORE_W'(prod_y_s2) + SCORE_W'(prod_z_s2);
		cut_sh  = {cut_s2, {FRACTION_BITS{1'b0}}};
		cut_ext = CMP_W'(cut_sh);
		dot_ext = CMP_W'(dot_sum);
	end

	always_comb begin
		res.busy      = valid_s2 | valid_s3;
		res.valid     = valid_s3;
		res.above_cut = above_s3;
		res.rank      = rank_s3;
		res.dot       = dot_s3;
		res.tag       = tag_s3;
	end

endmodule

### tb/priority_cone_point_labeler_tb.sv
// ---------------------------------------------------------------------------
// Priority cone point labeler testbench
// Drives load and classify requests through the valid/ready input, mirrors
// the region table and configuration in a local label predictor, and checks
// every returned label, score and hit flag in order. Directed tests cover
// reset defaults, the cut boundary, rank and score ties and the octant start
// label; random traffic then runs across several table sizes and octant
// settings, with bursty input and a stalling output.
// ---------------------------------------------------------------------------
module priority_cone_point_labeler_tb;

	import pcpl_pkg::*;

	localparam int MAX_REGIONS   = 16;
	localparam int FRACTION_BITS = 14;
	localparam int IDLE_CYCLES   = MAX_REGIONS + 24;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASE_ITEMS   = 240;

	typedef struct packed {
		logic [TAG_W-1:0]          label;
		logic signed [SCORE_W-1:0] score;
		logic                      hit;
	} label_result_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic                      cmd         = CMD_LOAD;
	logic [IDX_W-1:0]          entry_index = '0;
	logic signed [COORD_W-1:0] vec_x       = '0;
	logic signed [COORD_W-1:0] vec_y       = '0;
	logic signed [COORD_W-1:0] vec_z       = '0;
	logic signed [COORD_W-1:0] cut_value   = '0;
	logic signed [RANK_W-1:0]  region_rank = '0;
	logic [TAG_W-1:0]          region_tag  = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic [TAG_W-1:0]          point_label;
	logic signed [SCORE_W-1:0] best_score;
	logic                      region_hit;
	logic                      cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index   = REG_ACTIVE;
	logic [CFG_W-1:0]          cfg_wdata   = '0;

	entry_t              region_table [MAX_REGIONS];
	logic [ACTIVE_W-1:0] active_count = '0;
	logic                octant_on    = 1'b1;
	label_result_t       expected_labels [$];
	label_result_t       due;

	int error_count = 0;
	int cycle_count = 0;
	int burst_left  = 0;
	int ready_mode  = 0;
	int mode_left   = 0;

	priority_cone_point_labeler #(
		.MAX_REGIONS(MAX_REGIONS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.entry_index(entry_index),
		.vec_x(vec_x),
		.vec_y(vec_y),
		.vec_z(vec_z),
		.cut_value(cut_value),
		.region_rank(region_rank),
		.region_tag(region_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_label(point_label),
		.best_score(best_score),
		.region_hit(region_hit),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((cycle_count % 7) < 4);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_labels.size() == 0) begin
				$display("%0t: unexpected result point_label %h best_score %h region_hit %b",
					$time, point_label, best_score, region_hit);
				error_count++;
			end else begin
				due = expected_labels.pop_front();
				if (point_label !== due.label) begin
					$display("%0t: point_label expected %h actual %h",
						$time, due.label, point_label);
					error_count++;
				end
				if (best_score !== due.score) begin
					$display("%0t: best_score expected %h actual %h",
						$time, due.score, best_score);
					error_count++;
				end
				if (region_hit !== due.hit) begin
					$display("%0t: region_hit expected %b actual %b",
						$time, due.hit, region_hit);
					error_count++;
				end
			end
		end
	end

	function automatic label_result_t predict_label(point_t pt);
		label_result_t r;
		longint        dot;
		longint        cut_scaled;
		longint        best_dot;
		int            best_rank;
		int            scan;
		r.label   = '0;
		r.hit     = 1'b0;
		best_dot  = 0;
		best_rank = 0;
		if (octant_on)
			r.label[2:0] = {pt.z[COORD_W-1], pt.y[COORD_W-1], pt.x[COORD_W-1]};
		scan = (active_count > MAX_REGIONS) ? MAX_REGIONS : int'(active_count);
		for (int j = 0; j < scan; j++) begin
			dot = longint'($signed(pt.x)) * longint'($signed(region_table[j].x))
				+ longint'($signed(pt.y)) * longint'($signed(region_table[j].y))
				+ longint'($signed(pt.z)) * longint'($signed(region_table[j].z));
			cut_scaled = longint'($signed(region_table[j].cut)) * (longint'(1) << FRACTION_BITS);
			if (dot > cut_scaled && (int'($signed(region_table[j].rank)) > best_rank ||
				(int'($signed(region_table[j].rank)) == best_rank && dot > best_dot))) begin
				r.label   = region_table[j].tag;
				r.hit     = 1'b1;
				best_dot  = dot;
				best_rank = int'($signed(region_table[j].rank));
			end
		end
		r.score = best_dot[SCORE_W-1:0];
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] random_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return COORD_W'($urandom_range(0, 32) - 16);
			2, 3: return COORD_W'($urandom_range(0, 32768) - 16384);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic entry_t random_entry();
		entry_t e;
		e.x    = random_coord();
		e.y    = random_coord();
		e.z    = random_coord();
		e.cut  = random_coord();
		e.rank = RANK_W'($urandom_range(0, 1) ? $urandom_range(0, 4) - 1 : $urandom);
		e.tag  = TAG_W'($urandom);
		return e;
	endfunction

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic send_request(input logic req_cmd, input logic [IDX_W-1:0] slot,
		input entry_t fields);
		point_t pt;
		in_valid    <= 1'b1;
		cmd         <= req_cmd;
		entry_index <= slot;
		vec_x       <= fields.x;
		vec_y       <= fields.y;
		vec_z       <= fields.z;
		cut_value   <= fields.cut;
		region_rank <= fields.rank;
		region_tag  <= fields.tag;
		do @(posedge clk); while (!in_ready);
		if (req_cmd == CMD_LOAD) begin
			if (slot < MAX_REGIONS)
				region_table[slot] = fields;
		end else begin
			pt.x = fields.x;
			pt.y = fields.y;
			pt.z = fields.z;
			expected_labels.insert(expected_labels.size(), predict_label(pt));
		end
		pace_sender();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_labels.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACTIVE)
			active_count = value[ACTIVE_W-1:0];
		else
			octant_on = value[0];
	endtask

	task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z);
		entry_t e;
		e   = random_entry();
		e.x = x;
		e.y = y;
		e.z = z;
		send_request(CMD_CLASSIFY, IDX_W'($urandom), e);
	endtask

	task automatic test_reset_defaults();
		send_point(16'h0000, 16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'h0001, 16'h8000);
		send_point(16'h7FFF, 16'h8000, 16'h0001);
		send_point(16'h8000, 16'h8000, 16'h8000);
	endtask

	task automatic test_cut_boundary();
		write_reg(REG_ACTIVE, 5'd1);
		send_request(CMD_LOAD, 4'd0,
			'{x: 16'h4000, y: 16'h0000, z: 16'h0000, cut: 16'h2000, rank: 8'h01, tag: 16'hA5A5});
		send_point(16'h2000, 16'hFFFF, 16'hFFFF);
		send_point(16'h2001, 16'h0000, 16'h0000);
		send_point(16'h8000, 16'h7FFF, 16'h0000);
	endtask

	task automatic test_rank_priority();
		write_reg(REG_ACTIVE, 5'd5);
		send_request(CMD_LOAD, 4'd1,
			'{x: 16'h4000, y: 16'h0000, z: 16'h0000, cut: 16'h2000, rank: 8'h01, tag: 16'h5A5A});
		send_request(CMD_LOAD, 4'd2,
			'{x: 16'h0000, y: 16'h4000, z: 16'h0000, cut: 16'h8000, rank: 8'h01, tag: 16'hFFFF});
		send_request(CMD_LOAD, 4'd3,
			'{x: 16'h4000, y: 16'h4000, z: 16'h4000, cut: 16'h8000, rank: 8'h80, tag: 16'h1234});
		send_request(CMD_LOAD, 4'd4,
			'{x: 16'h8000, y: 16'h8000, z: 16'h8000, cut: 16'h7FFF, rank: 8'h7F, tag: 16'h0000});
		send_point(16'h4000, 16'h0064, 16'h0000);
		send_point(16'h0000, 16'h7FFF, 16'h0000);
		send_point(16'h8000, 16'h8000, 16'h8000);
	endtask

	task automatic test_octant_off();
		write_reg(REG_OCTANT, 5'd0);
		write_reg(REG_ACTIVE, 5'd0);
		send_point(16'hFFFB, 16'hFFFB, 16'hFFFB);
		send_point(16'h8000, 16'h8000, 16'h8000);
	endtask

	task automatic test_random_traffic();
		logic [ACTIVE_W-1:0] phase_active [8] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd9, 5'd0, 5'd16};
		entry_t              e;
		for (int s = 0; s < MAX_REGIONS; s++)
			send_request(CMD_LOAD, IDX_W'(s), random_entry());
		for (int p = 0; p < 8; p++) begin
			if (p == 6)
				phase_active[p] = ACTIVE_W'($urandom_range(0, 31));
			write_reg(REG_ACTIVE, phase_active[p]);
			write_reg(REG_OCTANT, CFG_W'((p < 4) ? p[0] : $urandom_range(0, 1)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					e = random_entry();
					if ($urandom_range(0, 9) == 0) begin
						e     = region_table[$urandom_range(0, MAX_REGIONS - 1)];
						e.tag = TAG_W'($urandom);
					end
					send_request(CMD_LOAD, IDX_W'($urandom), e);
				end else begin
					send_request(CMD_CLASSIFY, IDX_W'($urandom), random_entry());
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_cut_boundary();
		test_rank_priority();
		test_octant_off();
		test_random_traffic();
		wait_idle();
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
